[rtl/dopq_pkg.sv]
`default_nettype none
package dopq_pkg;

  localparam int unsigned SlotCountDef = 16;
  localparam int unsigned SlotSizeDef  = 64;

  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 7;

  localparam logic [CfgIdxW-1:0] CfgSlotsInUse = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgSlotBytes  = 1'd1;

  typedef enum logic [1:0] {
    ActPushByte  = 2'd0,
    ActPushEmpty = 2'd1,
    ActPop       = 2'd2,
    ActReset     = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    StPushed   = 3'd0,
    StRejected = 3'd1,
    StPopped   = 3'd2,
    StEmpty    = 3'd3,
    StTooSmall = 3'd4
  } status_e;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] data_in;
    logic       end_of_packet;
    logic [7:0] out_capacity;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  data_out;
    logic [6:0]  packet_length;
    logic        final_result;
    logic [4:0]  occupancy;
    logic [4:0]  peak_fill;
    logic [31:0] dropped_total;
    logic [31:0] rejected_total;
    logic [31:0] pushed_total;
    logic [31:0] popped_total;
    logic        queue_full;
  } out_item_t;

  typedef enum logic [2:0] {
    SIdle,
    SCopyRd,
    SCopy,
    SPopRd,
    SPop,
    SEmit
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic     take;       // latch input item, decode it
    logic     copy_start; // begin staging -> slot copy
    logic     copy_step;  // one byte of the copy
    logic     pop_start;  // begin streaming the head slot
    logic     pop_step;   // advance pop byte pointer
    logic     emit;       // load output register
    logic     emit_pop;   // emitted item is a popped byte
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic need_copy;   // committed packet has bytes to move
    logic need_pop;    // pop with bytes to stream
    logic need_emit;   // item gives one plain result
    logic copy_last;   // current copy byte is the last
    logic pop_last;    // current pop byte is the last
  } sts_t;

endpackage
`default_nettype wire

[rtl/dopq_ram.sv]
`default_nettype none
module dopq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  wire                      clk_i,
  input  wire                      we_i,
  input  wire [$clog2(Depth)-1:0]  waddr_i,
  input  wire [Width-1:0]          wdata_i,
  input  wire [$clog2(Depth)-1:0]  raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

[rtl/dopq_ctrl.sv]
`default_nettype none
module dopq_ctrl (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_stall_o,
  input  wire                out_stall_i,
  input  wire                out_busy_i,
  input  wire dopq_pkg::sts_t sts_i,
  output dopq_pkg::cmd_t     cmd_o
);
  import dopq_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // a new output may be loaded when the register is empty or drains now
  logic out_free;
  assign out_free = !out_busy_i || !out_stall_i;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      SIdle: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = SEmit;
        end
      end
      SEmit: begin
        // decoded item sits in the datapath
        if (sts_i.need_copy) begin
          cmd_o.copy_start = 1'b1;
          state_d          = SCopyRd;
        end else if (sts_i.need_pop) begin
          cmd_o.pop_start = 1'b1;
          state_d         = SPopRd;
        end else if (sts_i.need_emit) begin
          if (out_free) begin
            cmd_o.emit = 1'b1;
            state_d    = SIdle;
          end
        end else begin
          state_d = SIdle;
        end
      end
      SCopyRd: begin
        state_d = SCopy;
      end
      SCopy: begin
        cmd_o.copy_step = 1'b1;
        if (sts_i.copy_last) begin
          state_d = SPop; // reuse: go emit push result
        end
      end
      SPopRd: begin
        state_d = SPop;
      end
      SPop: begin
        if (sts_i.need_pop) begin
          if (out_free) begin
            cmd_o.emit     = 1'b1;
            cmd_o.emit_pop = 1'b1;
            cmd_o.pop_step = 1'b1;
            if (sts_i.pop_last) begin
              state_d = SIdle;
            end
          end
        end else if (out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end
endmodule
`default_nettype wire

[rtl/dopq_dp.sv]
`default_nettype none
module dopq_dp #(
  parameter int unsigned SlotCount = dopq_pkg::SlotCountDef,
  parameter int unsigned SlotSize  = dopq_pkg::SlotSizeDef
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_we_i,
  input  wire [dopq_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire [dopq_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire dopq_pkg::in_item_t      in_data_i,
  input  wire dopq_pkg::cmd_t          cmd_i,
  output dopq_pkg::sts_t               sts_o,
  input  wire                          out_stall_i,
  output logic                         out_valid_o,
  output dopq_pkg::out_item_t          out_data_o
);
  import dopq_pkg::*;

  localparam int unsigned SlotW  = (SlotCount > 1) ? $clog2(SlotCount) : 1;
  localparam int unsigned CntW   = $clog2(SlotCount + 1);
  localparam int unsigned ByteW  = (SlotSize > 1) ? $clog2(SlotSize) : 1;
  localparam int unsigned LenW   = $clog2(SlotSize + 1);
  localparam int unsigned StoreD = SlotCount * SlotSize;
  localparam int unsigned StoreW = $clog2(StoreD) > 0 ? $clog2(StoreD) : 1;
  localparam logic [CntW-1:0] SlotCountC = CntW'(SlotCount);
  localparam logic [6:0]      SlotSizeC  = 7'(SlotSize);

  // configuration and state
  logic [4:0]      slots_q;
  logic [6:0]      bytes_q;
  logic [LenW-1:0] stg_cnt_q;
  logic            stg_over_q;
  logic [SlotW-1:0] head_q;
  logic [CntW-1:0] cnt_q, peak_q;
  logic [31:0]     drop_q, rej_q, push_q, pop_q;
  logic [LenW-1:0] lengths_q [SlotCount];

  // item under work
  logic            need_copy_q, need_pop_q, need_emit_q;
  logic [2:0]      res_st_q;
  logic [LenW-1:0] res_len_q;
  logic [SlotW-1:0] slot_q;   // copy target or pop source slot
  logic [ByteW-1:0] ptr_q;    // byte pointer
  logic [LenW-1:0] left_q;    // bytes remaining

  // effective slots and length limit
  logic [CntW-1:0] n_eff;
  logic [6:0]      lim_eff;
  always_comb begin
    if (slots_q == 5'd0) begin
      n_eff = CntW'(1);
    end else if ({{(32-5){1'b0}}, slots_q} > 32'(SlotCount)) begin
      n_eff = SlotCountC;
    end else begin
      n_eff = CntW'(slots_q);
    end
    lim_eff = (bytes_q > SlotSizeC) ? SlotSizeC : bytes_q;
  end

  function automatic logic [SlotW-1:0] wrap_inc(logic [SlotW-1:0] v, logic [CntW-1:0] n);
    logic [CntW:0] s;
    s = {{(CntW+1-SlotW){1'b0}}, v} + 1'b1;
    if (s >= {1'b0, n}) begin
      s = '0;
    end
    return s[SlotW-1:0];
  endfunction

  // tail computation for commit (head already advanced if full)
  logic             full_now;
  logic [SlotW-1:0] head_c;
  logic [CntW-1:0]  cnt_c;
  logic [CntW:0]    tail_s;
  logic [SlotW-1:0] tail_c;
  always_comb begin
    full_now = cnt_q >= n_eff;
    head_c   = full_now ? wrap_inc(head_q, n_eff) : head_q;
    cnt_c    = full_now ? n_eff - 1'b1 : cnt_q;
    tail_s   = {{(CntW+1-SlotW){1'b0}}, head_c} + {1'b0, cnt_c};
    if (tail_s >= {1'b0, n_eff}) begin
      tail_s = tail_s - {1'b0, n_eff};
    end
    tail_c = tail_s[SlotW-1:0];
  end

  // staging byte acceptance
  logic stg_room;
  assign stg_room = {{(8-LenW){1'b0}}, stg_cnt_q} < {1'b0, lim_eff};

  // memories
  logic [7:0]       stg_rdata, sto_rdata;
  logic             stg_we, sto_we;
  logic [ByteW-1:0] stg_waddr;
  logic [StoreW-1:0] sto_addr_w, sto_addr_r;

  assign stg_we    = cmd_i.take && in_data_i.action == ActPushByte && stg_room;
  assign stg_waddr = stg_cnt_q[ByteW-1:0];
  assign sto_we    = cmd_i.copy_step;

  // copy writes follow the registered staging read; ptr_q is the byte in stg_rdata
  logic [ByteW-1:0] rd_ptr;
  assign rd_ptr = (cmd_i.copy_start || cmd_i.pop_start) ? '0 :
                  (cmd_i.copy_step || cmd_i.pop_step) ? ptr_q + 1'b1 : ptr_q;

  assign sto_addr_w = StoreW'({{(StoreW){1'b0}}, slot_q} * StoreW'(SlotSize))
                      + StoreW'(ptr_q);
  assign sto_addr_r = StoreW'({{(StoreW){1'b0}}, slot_q} * StoreW'(SlotSize))
                      + StoreW'(rd_ptr);

  dopq_ram #(.Width(8), .Depth(SlotSize)) u_stage (
    .clk_i   (clk_i),
    .we_i    (stg_we),
    .waddr_i (stg_waddr),
    .wdata_i (in_data_i.data_in),
    .raddr_i (rd_ptr),
    .rdata_o (stg_rdata)
  );

  dopq_ram #(.Width(8), .Depth(StoreD)) u_store (
    .clk_i   (clk_i),
    .we_i    (sto_we),
    .waddr_i (sto_addr_w),
    .wdata_i (stg_rdata),
    .raddr_i (sto_addr_r),
    .rdata_o (sto_rdata)
  );

  assign sts_o.need_copy = need_copy_q;
  assign sts_o.need_pop  = need_pop_q;
  assign sts_o.need_emit = need_emit_q;
  assign sts_o.copy_last = left_q == LenW'(1);
  assign sts_o.pop_last  = left_q == LenW'(1);

  // head packet fits the reader; decided at the take cycle
  logic [LenW-1:0] head_len;
  logic            pop_fit;
  assign head_len = lengths_q[head_q];
  assign pop_fit  = {{(9-LenW){1'b0}}, head_len} <= {1'b0, in_data_i.out_capacity};

  // commit bookkeeping shared by both push paths
  logic            do_commit;
  logic [LenW-1:0] commit_len;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slots_q     <= 5'd16;
      bytes_q     <= 7'd64;
      stg_cnt_q   <= '0;
      stg_over_q  <= 1'b0;
      head_q      <= '0;
      cnt_q       <= '0;
      peak_q      <= '0;
      drop_q      <= '0;
      rej_q       <= '0;
      push_q      <= '0;
      pop_q       <= '0;
      need_copy_q <= 1'b0;
      need_pop_q  <= 1'b0;
      need_emit_q <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        out_valid_o <= 1'b0;
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgSlotsInUse) begin
          slots_q <= cfg_data_i[4:0];
          head_q  <= '0;
          cnt_q   <= '0;
        end else if (cfg_idx_i == CfgSlotBytes) begin
          bytes_q <= cfg_data_i;
        end
      end
      if (do_commit) begin
        if (full_now) begin
          drop_q <= drop_q + 1'b1;
        end
        head_q <= head_c;
        cnt_q  <= cnt_c + 1'b1;
        push_q <= push_q + 1'b1;
        if (cnt_c + 1'b1 > peak_q) begin
          peak_q <= cnt_c + 1'b1;
        end
      end
      if (cmd_i.take) begin
        need_copy_q <= 1'b0;
        need_pop_q  <= 1'b0;
        need_emit_q <= 1'b0;
        case (in_data_i.action)
          ActPushByte: begin
            if (stg_room) begin
              stg_cnt_q <= stg_cnt_q + 1'b1;
            end else begin
              stg_over_q <= 1'b1;
            end
            if (in_data_i.end_of_packet) begin
              stg_cnt_q  <= '0;
              stg_over_q <= 1'b0;
              if (stg_over_q || !stg_room) begin
                rej_q       <= rej_q + 1'b1;
                need_emit_q <= 1'b1;
              end else begin
                need_copy_q <= 1'b1;
              end
            end
          end
          ActPushEmpty: need_emit_q <= 1'b1;
          ActPop: begin
            // a fitting head packet leaves the ring as soon as the pop is taken
            if (cnt_q != '0 && pop_fit) begin
              head_q <= wrap_inc(head_q, n_eff);
              cnt_q  <= cnt_q - 1'b1;
              pop_q  <= pop_q + 1'b1;
              if (head_len != '0) begin
                need_pop_q <= 1'b1;
              end else begin
                need_emit_q <= 1'b1;
              end
            end else begin
              need_emit_q <= 1'b1;
            end
          end
          ActReset: begin
            head_q     <= '0;
            cnt_q      <= '0;
            peak_q     <= '0;
            drop_q     <= '0;
            rej_q      <= '0;
            push_q     <= '0;
            pop_q      <= '0;
            stg_cnt_q  <= '0;
            stg_over_q <= 1'b0;
          end
          default: ;
        endcase
      end
      if (cmd_i.copy_start) begin
        need_copy_q <= 1'b0;
      end
      if (cmd_i.pop_step && sts_o.pop_last) begin
        need_pop_q <= 1'b0;
      end
      if (cmd_i.emit) begin
        out_valid_o <= 1'b1;
        need_emit_q <= 1'b0;
      end
    end
  end

  always_comb begin
    do_commit  = 1'b0;
    commit_len = '0;
    if (cmd_i.take && in_data_i.action == ActPushEmpty) begin
      do_commit = 1'b1;
    end else if (cmd_i.take && in_data_i.action == ActPushByte &&
                 in_data_i.end_of_packet && !stg_over_q && stg_room) begin
      do_commit  = 1'b1;
      commit_len = stg_cnt_q + 1'b1;
    end
  end

  // committed length note: with a zero limit every byte packet is rejected,
  // so a non-zero commit always comes from the byte path above
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      res_st_q  <= StPushed;
      res_len_q <= '0;
      if (in_data_i.action == ActPushByte && (stg_over_q || !stg_room)) begin
        res_st_q <= StRejected;
      end else if (in_data_i.action == ActPushByte) begin
        res_len_q <= commit_len;
      end else if (in_data_i.action == ActPop) begin
        res_st_q <= StEmpty;
        if (cnt_q != '0) begin
          res_st_q  <= pop_fit ? StPopped : StTooSmall;
          res_len_q <= head_len;
          slot_q    <= head_q;
          left_q    <= head_len;
        end
      end
      if (do_commit) begin
        lengths_q[tail_c] <= commit_len;
        slot_q            <= tail_c;
        left_q            <= commit_len;
      end
    end
    if (cmd_i.copy_start || cmd_i.pop_start) begin
      ptr_q <= '0;
    end
    if (cmd_i.copy_step) begin
      ptr_q  <= ptr_q + 1'b1;
      left_q <= left_q - 1'b1;
      if (sts_o.copy_last) begin
        left_q <= '0;
      end
    end
    if (cmd_i.pop_step) begin
      ptr_q  <= ptr_q + 1'b1;
      left_q <= left_q - 1'b1;
    end
    if (cmd_i.emit) begin
      out_data_o.status        <= res_st_q;
      out_data_o.data_out      <= cmd_i.emit_pop ? sto_rdata : 8'd0;
      out_data_o.packet_length <= 7'(res_len_q);
      out_data_o.final_result  <= cmd_i.emit_pop ? sts_o.pop_last : 1'b1;
      out_data_o.occupancy     <= 5'(cnt_q);
      out_data_o.peak_fill     <= 5'(peak_q);
      out_data_o.dropped_total <= drop_q;
      out_data_o.rejected_total <= rej_q;
      out_data_o.pushed_total  <= push_q;
      out_data_o.popped_total  <= pop_q;
      out_data_o.queue_full    <= (cnt_q == n_eff);
    end
  end
endmodule
`default_nettype wire

[rtl/drop_oldest_packet_queue.sv]
`default_nettype none
// Drop-oldest packet queue.
// Input channel in_valid_i/in_stall_o carries one transaction per action:
// push byte, push empty packet, pop packet, or clear queue and statistics.
// Output channel out_valid_o/out_stall_i carries result transactions; every
// result also carries the occupancy and statistics after the action.
// Configuration is a plain write port (cfg_we_i, cfg_idx_i, cfg_data_i):
// index 0 slots in use (empties the ring), index 1 slot byte limit.
// A committed packet is copied byte by byte from the staging RAM into the
// slot RAM. A pop gives one result per cycle while the output is not
// stalled, limited by the single read port of the slot RAM. One
// transaction is worked at a time.
// Reset: ring empty, statistics zero, 16 slots of 64 bytes; RAM contents
// are not cleared and need no clearing pass.
// A stalled output holds its result; the engine waits until it drains.
module drop_oldest_packet_queue #(
  parameter int unsigned SlotCount = dopq_pkg::SlotCountDef,
  parameter int unsigned SlotSize  = dopq_pkg::SlotSizeDef
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_we_i,
  input  wire [dopq_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire [dopq_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire                          in_valid_i,
  output logic                         in_stall_o,
  input  wire dopq_pkg::in_item_t      in_data_i,
  output logic                         out_valid_o,
  input  wire                          out_stall_i,
  output dopq_pkg::out_item_t          out_data_o
);
  import dopq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  dopq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_stall_i (out_stall_i),
    .out_busy_i  (out_valid_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  dopq_dp #(.SlotCount(SlotCount), .SlotSize(SlotSize)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );
endmodule
`default_nettype wire

[bench/tb_drop_oldest_packet_queue.sv]
`default_nettype none
// Drop-oldest packet queue bench: a negedge driver feeds transactions from a
// pending queue, a posedge monitor runs a local model of the ring on each
// accepted transaction and checks every result transaction in order.
module tb_drop_oldest_packet_queue;
  import dopq_pkg::*;

  localparam int unsigned CycleLimit = 1500000;
  localparam int unsigned SettleCycles = 16;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  in_item_t            in_data_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  out_item_t           out_data_o;

  drop_oldest_packet_queue dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Local model of the ring: state mirrors the block, updated on acceptance
  // ---------------------------------------------------------------------------
  logic [7:0]  ring_bytes [16][64];
  logic [6:0]  ring_len [16];
  logic [7:0]  stage_bytes [64];
  int unsigned stage_cnt, head, fill, peak;
  bit          stage_over;
  logic [31:0] n_drop, n_reject, n_push, n_pop;
  int unsigned reg_slots = 16, reg_bytes = 64;

  out_item_t   results_due [$];
  in_item_t    pending_tx [$];
  int unsigned fail_cnt = 0;
  int unsigned cycles = 0;
  bit          quiet = 1'b0;   // no idling in the closing stretch
  bit          in_taken = 1'b0;

  function automatic int unsigned ring_slots();
    if (reg_slots == 0) return 1;
    if (reg_slots > 16) return 16;
    return reg_slots;
  endfunction

  function automatic int unsigned byte_limit();
    return (reg_bytes > 64) ? 64 : reg_bytes;
  endfunction

  // every result carries the statistics as they stand after the step
  function automatic out_item_t make_result(status_e st, logic [7:0] d, int unsigned len,
                                            bit fin);
    out_item_t r;
    r.status         = st;
    r.data_out       = d;
    r.packet_length  = len[6:0];
    r.final_result   = fin;
    r.occupancy      = fill[4:0];
    r.peak_fill      = peak[4:0];
    r.dropped_total  = n_drop;
    r.rejected_total = n_reject;
    r.pushed_total   = n_push;
    r.popped_total   = n_pop;
    r.queue_full     = (fill == ring_slots());
    return r;
  endfunction

  function automatic void ring_commit(int unsigned len);
    int unsigned n, tail;
    n = ring_slots();
    if (fill >= n) begin
      // full: drop the oldest packet to make room
      head = (head + 1) % n;
      fill = n - 1;
      n_drop++;
    end
    tail = (head + fill) % n;
    for (int i = 0; i < len; i++) ring_bytes[tail][i] = stage_bytes[i];
    ring_len[tail] = len[6:0];
    fill++;
    n_push++;
    if (fill > peak) peak = fill;
  endfunction

  function automatic void clear_all();
    head = 0; fill = 0; peak = 0;
    n_drop = 0; n_reject = 0; n_push = 0; n_pop = 0;
    stage_cnt = 0; stage_over = 1'b0;
  endfunction

  function automatic void model_transaction(in_item_t t);
    int unsigned n, h, len;
    case (action_e'(t.action))
      ActPushByte: begin
        if (stage_cnt < byte_limit()) begin
          stage_bytes[stage_cnt] = t.data_in;
          stage_cnt++;
        end else begin
          stage_over = 1'b1;
        end
        if (t.end_of_packet) begin
          if (stage_over) begin
            n_reject++;
            stage_cnt = 0;
            stage_over = 1'b0;
            results_due.push_back(make_result(StRejected, 8'd0, 0, 1'b1));
          end else begin
            len = stage_cnt;
            ring_commit(len);
            stage_cnt = 0;
            results_due.push_back(make_result(StPushed, 8'd0, len, 1'b1));
          end
        end
      end
      ActPushEmpty: begin
        // staged bytes are left alone
        ring_commit(0);
        results_due.push_back(make_result(StPushed, 8'd0, 0, 1'b1));
      end
      ActPop: begin
        n = ring_slots();
        if (fill == 0) begin
          results_due.push_back(make_result(StEmpty, 8'd0, 0, 1'b1));
        end else begin
          h = head % n;
          len = ring_len[h];
          if (len > 64) len = 64;
          if (len > t.out_capacity) begin
            results_due.push_back(make_result(StTooSmall, 8'd0, len, 1'b1));
          end else begin
            head = (h + 1) % n;
            fill--;
            n_pop++;
            if (len == 0) results_due.push_back(make_result(StPopped, 8'd0, 0, 1'b1));
            for (int i = 0; i < len; i++)
              results_due.push_back(make_result(StPopped, ring_bytes[h][i], len, i + 1 == len));
          end
        end
      end
      default: clear_all();
    endcase
  endfunction

  task automatic report_field(string name, logic [31:0] e, logic [31:0] a);
    if (e !== a) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, e, a);
      fail_cnt++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: acceptance on both channels and register writes, at rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    out_item_t e;
    cycles++;
    if (rst_ni) begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgSlotsInUse) begin
          reg_slots = cfg_data_i & 7'h1F;
          head = 0;
          fill = 0;
        end else if (cfg_idx_i == CfgSlotBytes) begin
          reg_bytes = cfg_data_i;
        end
      end
      if (out_valid_o && !out_stall_i) begin
        if (results_due.size() == 0) begin
          $display("%0t: unexpected result, expected none actual %0h", $time, out_data_o);
          fail_cnt++;
        end else begin
          e = results_due.pop_front();
          report_field("status", e.status, out_data_o.status);
          report_field("data_out", e.data_out, out_data_o.data_out);
          report_field("packet_length", e.packet_length, out_data_o.packet_length);
          report_field("final_result", e.final_result, out_data_o.final_result);
          report_field("occupancy", e.occupancy, out_data_o.occupancy);
          report_field("peak_fill", e.peak_fill, out_data_o.peak_fill);
          report_field("dropped_total", e.dropped_total, out_data_o.dropped_total);
          report_field("rejected_total", e.rejected_total, out_data_o.rejected_total);
          report_field("pushed_total", e.pushed_total, out_data_o.pushed_total);
          report_field("popped_total", e.popped_total, out_data_o.popped_total);
          report_field("queue_full", e.queue_full, out_data_o.queue_full);
        end
      end
      if (in_valid_i && !in_stall_o) begin
        model_transaction(in_data_i);
        in_taken = 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver and back-pressure, at falling edge; idling comes in bursts
  // ---------------------------------------------------------------------------
  int unsigned in_gap = 0, stall_gap = 0;

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_taken) begin
        in_taken = 1'b0;
        if (in_gap > 0) begin
          in_valid_i <= 1'b0;
          in_gap--;
        end else if (pending_tx.size() > 0) begin
          in_data_i <= pending_tx.pop_front();
          in_valid_i <= 1'b1;
          if (!quiet && $urandom_range(0, 7) == 0) in_gap = $urandom_range(1, 17);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      if (stall_gap > 0) begin
        out_stall_i <= 1'b1;
        stall_gap--;
      end else begin
        out_stall_i <= 1'b0;
        if (!quiet && $urandom_range(0, 5) == 0) stall_gap = $urandom_range(1, 17);
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycles > CycleLimit) begin
      $display("drop_oldest_packet_queue: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  function automatic in_item_t tx(action_e a, logic [7:0] d, bit eop, logic [7:0] cap);
    in_item_t t;
    t.action = a;
    t.data_in = d;
    t.end_of_packet = eop;
    t.out_capacity = cap;
    return t;
  endfunction

  // one packet of len bytes; the final byte carries end_of_packet
  task automatic queue_packet(int unsigned len);
    for (int i = 0; i < len; i++)
      pending_tx.push_back(tx(ActPushByte, 8'($urandom), i + 1 == len, 8'($urandom)));
  endtask

  task automatic queue_pop(logic [7:0] cap);
    pending_tx.push_back(tx(ActPop, 8'($urandom), 1'($urandom), cap));
  endtask

  task automatic wait_drained();
    while (pending_tx.size() > 0 || in_valid_i || results_due.size() > 0)
      @(posedge clk_i);
    // non-final bytes and the clear action give no result: let them finish
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_traffic(int unsigned n_items);
    int unsigned sent, r, len;
    sent = 0;
    while (sent < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 48) begin
        // mostly short packets, a few at and past the byte limit
        if ($urandom_range(0, 9) == 0) len = $urandom_range(byte_limit(), byte_limit() + 2);
        else len = $urandom_range(1, 6);
        if (len == 0) len = 1;
        queue_packet(len);
        sent += len;
      end else if (r < 56) begin
        pending_tx.push_back(tx(ActPushEmpty, 8'($urandom), 1'($urandom), 8'($urandom)));
        sent++;
      end else if (r < 90) begin
        queue_pop(($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'hFF);
        sent++;
      end else if (r < 92) begin
        pending_tx.push_back(tx(ActReset, 8'($urandom), 1'($urandom), 8'($urandom)));
        sent++;
      end else begin
        // stray non-final byte: left in staging for a later packet
        pending_tx.push_back(tx(ActPushByte, 8'($urandom), 1'b0, 8'($urandom)));
        sent++;
      end
    end
  endtask

  initial begin
    ring_bytes = '{default: '{default: '0}};
    ring_len = '{default: '0};
    stage_bytes = '{default: '0};
    clear_all();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: full-size ring, all actions and corner cases
    write_reg(CfgSlotsInUse, 7'd16);
    write_reg(CfgSlotBytes, 7'd64);
    queue_pop(8'hFF);                                  // empty queue
    pending_tx.push_back(tx(ActPushByte, 8'hFF, 1'b0, 8'h00));
    pending_tx.push_back(tx(ActPushByte, 8'h00, 1'b0, 8'hFF));
    pending_tx.push_back(tx(ActPushByte, 8'hA5, 1'b1, 8'h00));
    queue_pop(8'd0);                                   // reader too small
    queue_pop(8'hFF);
    pending_tx.push_back(tx(ActPushByte, 8'h5A, 1'b0, 8'h00));
    pending_tx.push_back(tx(ActPushEmpty, 8'h00, 1'b0, 8'h00));  // while staging
    queue_pop(8'd0);                                   // zero-length pop
    pending_tx.push_back(tx(ActPushByte, 8'hC3, 1'b1, 8'h00));
    queue_pop(8'hFF);
    pending_tx.push_back(tx(ActReset, 8'h00, 1'b0, 8'h00));
    queue_pop(8'hFF);
    wait_drained();

    // single slot, zero byte limit: every byte packet rejected, drops on empties
    write_reg(CfgSlotsInUse, 7'd1);
    write_reg(CfgSlotBytes, 7'd0);
    queue_packet(1);
    pending_tx.push_back(tx(ActPushEmpty, 8'h00, 1'b0, 8'h00));
    pending_tx.push_back(tx(ActPushEmpty, 8'h00, 1'b0, 8'h00));
    queue_pop(8'hFF);
    random_traffic(30);
    wait_drained();

    // out-of-range registers: slots 0 acts as one, large limit clamps
    write_reg(CfgSlotsInUse, 7'd0);
    write_reg(CfgSlotBytes, 7'd127);
    queue_packet(64);
    queue_packet(65);
    queue_pop(8'hFF);
    random_traffic(30);
    wait_drained();

    write_reg(CfgSlotsInUse, 7'd31);
    write_reg(CfgSlotBytes, 7'd5);
    for (int i = 0; i < 18; i++) queue_packet(1);     // wrap and drop oldest
    random_traffic(60);
    wait_drained();

    write_reg(CfgSlotsInUse, 7'd3);
    write_reg(CfgSlotBytes, 7'd8);
    random_traffic(80);
    wait_drained();

    // limit lowered with packets stored: only later commits see it
    write_reg(CfgSlotBytes, 7'd2);
    quiet = 1'b1;
    random_traffic(50);
    wait_drained();

    repeat (100) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("drop_oldest_packet_queue: match");
    end else begin
      $display("drop_oldest_packet_queue: mismatch");
    end
    $finish;
  end

endmodule
`default_nettype wire

[drop_oldest_packet_queue.f]
rtl/dopq_pkg.sv
rtl/dopq_ram.sv
rtl/dopq_ctrl.sv
rtl/dopq_dp.sv
rtl/drop_oldest_packet_queue.sv
bench/tb_drop_oldest_packet_queue.sv
